### hw/rtl/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg
// Types, codes and helpers shared by the sorted record table.
// ----------------------------------------------------------------------------
package srt_pkg;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;
	localparam logic [1:0] OP_LIST   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_EMPTY     = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	localparam logic [2:0] ORD_INSERTION = 3'd0;
	localparam logic [2:0] ORD_NAME_UP   = 3'd1;
	localparam logic [2:0] ORD_NAME_DOWN = 3'd2;
	localparam logic [2:0] ORD_AGE_UP    = 3'd3;
	localparam logic [2:0] ORD_AGE_DOWN  = 3'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [63:0] key_name;
		logic [7:0]  age_value;
		logic [30:0] phone_value;
		logic [2:0]  list_order;
	} srt_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] out_name;
		logic [7:0]  out_age;
		logic [30:0] out_phone;
		logic        last_of_run;
	} srt_rsp_t;

	typedef struct packed {
		logic [63:0] name;
		logic [7:0]  age;
		logic [30:0] phone;
	} srt_rec_t;

	function automatic logic [63:0] norm_name(input logic [63:0] k, input int chars);
		logic [63:0] r;
		logic        stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= chars || k[63 - 8 * i -: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				r[63 - 8 * i -: 8] = k[63 - 8 * i -: 8];
		end
		return r;
	endfunction

	function automatic logic goes_before(input srt_rec_t a, input srt_rec_t b,
		input logic [2:0] order);
		logic r;
		case (order)
			ORD_NAME_UP:   r = a.name < b.name;
			ORD_NAME_DOWN: r = a.name > b.name;
			ORD_AGE_UP:    r = a.age < b.age;
			ORD_AGE_DOWN:  r = a.age > b.age;
			default:       r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### hw/rtl/srt_mem.sv
// ----------------------------------------------------------------------------
// srt_mem
// Record memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module srt_mem
	import srt_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  srt_rec_t      wdata,
	input  logic [AW-1:0] raddr,
	output srt_rec_t      rdata
);

	srt_rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

### hw/rtl/srt_out_reg.sv
// ----------------------------------------------------------------------------
// srt_out_reg
// Result register that holds one item until the receiver takes it.
// ----------------------------------------------------------------------------
module srt_out_reg
	import srt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     load,
	input  srt_rsp_t load_data,
	output logic     free,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output srt_rsp_t rsp
);

	logic valid_q;

	assign rsp_valid = valid_q;
	assign free      = !valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			rsp <= load_data;
	end

endmodule

### hw/rtl/sorted_record_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_record_table_unit
// Record table with insert, delete, lookup and stable sorted listing.
// ----------------------------------------------------------------------------
// One item is worked at a time. Insert, a full table and an empty table go
// straight to the result handoff. Delete reads and checks each entry up to
// the match, then shifts the rest down, reading each next entry and writing it
// one place lower; a name that is not found is reported after the full scan.
// Lookup makes two scans of the table. A list emits each of its n results
// after a full scan. Every scan step goes through the single read port of the
// record memory, whose read data is registered; a stalled result adds its wait.
module sorted_record_table_unit
	import srt_pkg::*;
#(
	parameter int DEPTH      = 32,
	parameter int NAME_CHARS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  srt_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output srt_rsp_t rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_EMIT, S_D_RD, S_D_CK, S_SH_RD, S_SH_WR,
		S_L1_RD, S_L1_CK, S_L2_RD, S_L2_CK, S_LS_RD, S_LS_CK
	} state_t;

	state_t          state_q, after_q;
	logic [CW-1:0]   cnt_q, idx_q, rank_q;
	logic [AW-1:0]   lastm_q, best_idx_q;
	logic            any_q, best_v_q;
	logic [DEPTH-1:0] done_q;
	logic [63:0]     key_q;
	logic [2:0]      order_q;
	srt_rec_t        gone_q, best_q;
	srt_rsp_t        res_q;

	logic            we, out_free, load, accept, take;
	logic [AW-1:0]   waddr, raddr, sel_idx;
	srt_rec_t        wdata, rdata, req_rec, sel_rec;
	logic [CW-1:0]   idx_nx;
	logic            idx_last, match;

	assign accept  = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign load    = (state_q == S_EMIT) && out_free;
	assign req_rec = '{name: norm_name(req.key_name, NAME_CHARS),
		age: req.age_value, phone: req.phone_value};
	assign idx_nx  = idx_q + 1'b1;
	assign idx_last = (idx_nx == cnt_q);
	assign match   = (rdata.name == key_q);
	assign take    = !done_q[idx_q[AW-1:0]] &&
		(!best_v_q || goes_before(rdata, best_q, order_q));
	assign sel_rec = take ? rdata : best_q;
	assign sel_idx = take ? idx_q[AW-1:0] : best_idx_q;

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = req_rec;
		raddr = idx_q[AW-1:0];
		if (state_q == S_IDLE && accept && req.opcode == OP_INSERT &&
			cnt_q != CW'(DEPTH))
			we = 1'b1;
		if (state_q == S_SH_RD)
			raddr = idx_nx[AW-1:0];
		if (state_q == S_SH_WR) begin
			we    = 1'b1;
			waddr = idx_q[AW-1:0];
			wdata = rdata;
		end
	end

	srt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	srt_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.load_data (res_q),
		.free      (out_free),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			after_q <= S_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			rank_q  <= '0;
			any_q   <= 1'b0;
			best_v_q <= 1'b0;
			done_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q   <= req_rec.name;
						order_q <= req.list_order;
						idx_q   <= '0;
						rank_q  <= '0;
						any_q   <= 1'b0;
						best_v_q <= 1'b0;
						done_q  <= '0;
						after_q <= S_IDLE;
						if (req.opcode == OP_INSERT) begin
							state_q <= S_EMIT;
							if (cnt_q == CW'(DEPTH)) begin
								res_q <= '{ST_FULL, 64'd0, 8'd0, 31'd0, 1'b1};
							end else begin
								res_q <= '{ST_OK, req_rec.name, req_rec.age,
									req_rec.phone, 1'b1};
								cnt_q <= cnt_q + 1'b1;
							end
						end else if (cnt_q == '0) begin
							state_q <= S_EMIT;
							res_q <= '{ST_EMPTY, 64'd0, 8'd0, 31'd0, 1'b1};
						end else if (req.opcode == OP_DELETE) begin
							state_q <= S_D_RD;
						end else if (req.opcode == OP_LOOKUP) begin
							state_q <= S_L1_RD;
						end else begin
							state_q <= S_LS_RD;
						end
					end
				end
				S_EMIT: begin
					if (out_free)
						state_q <= after_q;
				end
				S_D_RD: state_q <= S_D_CK;
				S_D_CK: begin
					if (match) begin
						gone_q  <= rdata;
						state_q <= S_SH_RD;
					end else if (idx_last) begin
						res_q <= '{ST_NOT_FOUND, 64'd0, 8'd0, 31'd0, 1'b1};
						state_q <= S_EMIT;
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_D_RD;
					end
				end
				S_SH_RD: begin
					if (idx_last) begin
						cnt_q <= cnt_q - 1'b1;
						res_q <= '{ST_OK, gone_q.name, gone_q.age, gone_q.phone, 1'b1};
						state_q <= S_EMIT;
					end else begin
						state_q <= S_SH_WR;
					end
				end
				S_SH_WR: begin
					idx_q   <= idx_nx;
					state_q <= S_SH_RD;
				end
				S_L1_RD: state_q <= S_L1_CK;
				S_L1_CK: begin
					if (match) begin
						lastm_q <= idx_q[AW-1:0];
						any_q   <= 1'b1;
					end
					if (idx_last) begin
						idx_q <= '0;
						if (!match && !any_q) begin
							res_q <= '{ST_NOT_FOUND, 64'd0, 8'd0, 31'd0, 1'b1};
							state_q <= S_EMIT;
						end else begin
							state_q <= S_L2_RD;
						end
					end else begin
						idx_q   <= idx_nx;
						state_q <= S_L1_RD;
					end
				end
				S_L2_RD: state_q <= S_L2_CK;
				S_L2_CK: begin
					idx_q <= idx_nx;
					if (match) begin
						res_q <= '{ST_OK, rdata.name, rdata.age, rdata.phone,
							idx_q[AW-1:0] == lastm_q};
						after_q <= (idx_q[AW-1:0] == lastm_q) ? S_IDLE : S_L2_RD;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_L2_RD;
					end
				end
				S_LS_RD: state_q <= S_LS_CK;
				S_LS_CK: begin
					if (idx_last) begin
						res_q <= '{ST_OK, sel_rec.name, sel_rec.age, sel_rec.phone,
							rank_q + 1'b1 == cnt_q};
						done_q[sel_idx] <= 1'b1;
						rank_q   <= rank_q + 1'b1;
						idx_q    <= '0;
						best_v_q <= 1'b0;
						after_q  <= (rank_q + 1'b1 == cnt_q) ? S_IDLE : S_LS_RD;
						state_q  <= S_EMIT;
					end else begin
						best_q     <= sel_rec;
						best_idx_q <= sel_idx;
						best_v_q   <= best_v_q || take;
						idx_q      <= idx_nx;
						state_q    <= S_LS_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != $past(cnt_q) |->
		(cnt_q == $past(cnt_q) + 1'b1 || cnt_q == $past(cnt_q) - 1'b1))
		else $error("entry count jumped");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		load && res_q.status != ST_OK |-> res_q.last_of_run)
		else $error("error result not final");
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		we && state_q == S_IDLE |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert write without count update");
`endif

endmodule
